### sv/pmm_pkg.sv
// pmm_pkg: shared types and constants of the paged memory mapper.
// Depends on nothing; used by every module of the block.
package pmm_pkg;

   // Installed RAM size in bytes, default for the top-level parameter.
   localparam int unsigned RAM_BYTES_DEFAULT = 131072;

   // Item modes
   localparam logic [1:0] MODE_CTL_WRITE = 2'd0;
   localparam logic [1:0] MODE_ENT_WRITE = 2'd1;
   localparam logic [1:0] MODE_XLATE     = 2'd2;

   // Targets
   localparam logic [1:0] TGT_RAM  = 2'd0;
   localparam logic [1:0] TGT_ROM  = 2'd1;
   localparam logic [1:0] TGT_CON  = 2'd2;
   localparam logic [1:0] TGT_SDIO = 2'd3;

   // Control byte bits
   localparam int unsigned CTL_ROM_OFF_BIT = 7;
   localparam int unsigned CTL_TBL_SEL_BIT = 6;
   localparam int unsigned CTL_ENABLE_BIT  = 5;
   localparam int unsigned CTL_IGNORE_BIT  = 4;

   // Page entry bits
   localparam int unsigned ENT_PROTECT_BIT = 7;

   // I/O window FF80-FFFF: address bits 15..7 all ones, slot in bits 6..3
   localparam logic [8:0] WINDOW_TAG = 9'h1FF;
   localparam logic [3:0] SLOT_CON   = 4'd10;
   localparam logic [3:0] SLOT_SDIO  = 4'd11;

   localparam logic [2:0] TOP_PAGE   = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  data_byte;
      logic [15:0] cpu_address;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [19:0] phys_offset;
      logic        writable;
      logic        beyond_ram;
   } rsp_item_type;

   // State update command from the item stage to the register file
   typedef struct packed {
      logic       ctl_we;
      logic       ent_we;
      logic [7:0] data;
   } wr_cmd_type;

endpackage

### sv/pmm_regs.sv
// pmm_regs: control byte and 16-entry page table.
// Depends on pmm_pkg.
module pmm_regs (
   input  logic               clock,
   input  logic               reset,
   input  pmm_pkg::wr_cmd_type wr,
   input  logic [3:0]         entry_index,
   output logic [7:0]         control,
   output logic [7:0]         entry
);
   import pmm_pkg::*;

   logic [7:0] control_ff;
   logic [7:0] table_ff [16];

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         for (int i = 0; i < 16; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         if (wr.ctl_we) begin
            control_ff <= wr.data;
         end
         if (wr.ent_we) begin
            table_ff[control_ff[3:0]] <= wr.data;
         end
      end
   end

   assign control = control_ff;
   assign entry   = table_ff[entry_index];

endmodule

### sv/pmm_xlate.sv
// pmm_xlate: combinational address translation for one item.
// Depends on pmm_pkg.
module pmm_xlate #(
   parameter int unsigned RAM_BYTES = pmm_pkg::RAM_BYTES_DEFAULT
) (
   input  logic                  item_valid,
   input  pmm_pkg::req_item_type item,
   input  logic [7:0]            control,
   input  logic [7:0]            entry,
   output logic [3:0]            entry_index,
   output pmm_pkg::rsp_item_type result
);
   import pmm_pkg::*;

   localparam logic [20:0] RamLimit = 21'(RAM_BYTES);

   logic [2:0]  page;
   logic [12:0] in_page;
   logic [3:0]  slot;
   logic        in_window;
   logic [19:0] ram_off;
   logic        ram_wr;

   assign page      = item.cpu_address[15:13];
   assign in_page   = item.cpu_address[12:0];
   assign slot      = item.cpu_address[6:3];
   assign in_window = (item.cpu_address[15:7] == WINDOW_TAG);

   assign entry_index = {control[CTL_TBL_SEL_BIT], page};

   // Block number lands above the 13 in-page bits, so no carry
   always_comb begin
      if (control[CTL_ENABLE_BIT]) begin
         ram_off = {entry[6:0], in_page};
         ram_wr  = !entry[ENT_PROTECT_BIT];
      end else begin
         ram_off = {4'd0, page, in_page};
         ram_wr  = 1'b1;
      end
   end

   always_comb begin
      result = '0;
      if (item_valid && item.mode == MODE_XLATE) begin
         if (in_window && (slot == SLOT_CON || slot == SLOT_SDIO)) begin
            result.target      = (slot == SLOT_CON) ? TGT_CON : TGT_SDIO;
            result.phys_offset = {17'd0, item.cpu_address[2:0]};
            result.writable    = 1'b1;
         end else if (page == TOP_PAGE && !control[CTL_ROM_OFF_BIT]) begin
            result.target      = TGT_ROM;
            result.phys_offset = {7'd0, in_page};
         end else begin
            result.target      = TGT_RAM;
            result.phys_offset = ram_off;
            result.writable    = ram_wr;
            result.beyond_ram  = ({1'b0, ram_off} >= RamLimit);
         end
      end
   end

endmodule

### sv/paged_memory_mapper.sv
// paged_memory_mapper: top level of the 8K-page memory mapper.
// Depends on pmm_pkg, pmm_regs and pmm_xlate.
//
// Usage
//   Items enter on req_item and are taken at a clock edge where start is
//   high and busy is low. busy is always low: one item can enter every
//   cycle. mode 0 writes the control byte (dropped when data bit 4 is
//   set), mode 1 writes the page entry the control pointer names, mode 2
//   translates cpu_address into target, phys_offset, writable and
//   beyond_ram. Writes and the unused mode give an all-zero result.
//
//   Every item gives exactly one result on rsp_item, flagged by
//   rsp_strobe for one cycle. The item is captured in the input
//   register, translated against the current control byte and page
//   table, and the result is captured in the output register. State
//   writes land at the end of the translate cycle, so an item sees
//   every write that entered before it. Throughput: one item per cycle.
//
//   The receiver cannot stall; results are never held back.
//   Synchronous reset clears the control byte, all 16 page entries and
//   both valid flags; no result is pending after reset.
module paged_memory_mapper #(
   parameter int unsigned RAM_BYTES = pmm_pkg::RAM_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pmm_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output pmm_pkg::rsp_item_type rsp_item
);
   import pmm_pkg::*;

   // Input register
   logic         req_valid_ff, req_valid_in;
   req_item_type req_ff, req_in;

   // Output register
   logic         rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type rsp_ff, rsp_in;

   wr_cmd_type   wr;
   logic [7:0]   control;
   logic [7:0]   entry;
   logic [3:0]   entry_index;

   assign busy = 1'b0;

   assign req_valid_in = start && !busy;
   assign req_in       = req_item;

   // Decode the registered item into state writes
   always_comb begin
      wr.data   = req_ff.data_byte;
      wr.ctl_we = req_valid_ff && req_ff.mode == MODE_CTL_WRITE
                  && !req_ff.data_byte[CTL_IGNORE_BIT];
      wr.ent_we = req_valid_ff && req_ff.mode == MODE_ENT_WRITE;
   end

   pmm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .entry_index (entry_index),
      .control     (control),
      .entry       (entry)
   );

   pmm_xlate #(
      .RAM_BYTES (RAM_BYTES)
   ) u_xlate (
      .item_valid  (req_valid_ff),
      .item        (req_ff),
      .control     (control),
      .entry       (entry),
      .entry_index (entry_index),
      .result      (rsp_in)
   );

   assign rsp_strobe_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

### sv/pmm_checker.sv
// pmm_checker: port-level checks of the paged memory mapper, bound to the top.
// Depends on pmm_pkg and paged_memory_mapper.
module pmm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input pmm_pkg::req_item_type req_item,
   input logic                  rsp_strobe,
   input pmm_pkg::rsp_item_type rsp_item
);
   import pmm_pkg::*;

   logic unused_req;
   assign unused_req = ^req_item;

   // Every accepted item gives a result through the input and output registers
   a_item_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted item produced no result");

   // No result without an accepted item ahead of it
   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   // I/O slots are writable and only 8 bytes wide
   a_io_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.target == TGT_CON || rsp_item.target == TGT_SDIO))
      |-> (rsp_item.writable && rsp_item.phys_offset[19:3] == '0
           && !rsp_item.beyond_ram))
      else $error("bad I/O slot result");

   // ROM is read-only, never flagged beyond RAM, and within one page
   a_rom: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.target == TGT_ROM)
      |-> (!rsp_item.writable && !rsp_item.beyond_ram
           && rsp_item.phys_offset[19:13] == '0))
      else $error("bad ROM result");

endmodule

bind paged_memory_mapper pmm_checker u_pmm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

### tb/pmm_bus_checker.sv
`timescale 1ns / 1ps
// pmm_bus_checker: watches the item and result channels of paged_memory_mapper and
// predicts every result from its own copy of the control byte and page table.
// Depends on pmm_pkg.
module pmm_bus_checker #(
   parameter int unsigned RAM_BYTES = pmm_pkg::RAM_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  pmm_pkg::req_item_type req_item,
   input  logic                  rsp_strobe,
   input  pmm_pkg::rsp_item_type rsp_item,
   output int                    mismatch_count,
   output int                    pending_count
);
   import pmm_pkg::*;

   logic [7:0]   control_byte;
   logic [7:0]   page_entries [16];
   rsp_item_type mapping_q [$];
   rsp_item_type oldest;
   int           errors = 0;

   // Expected result of one item under the current control byte and table.
   function automatic rsp_item_type expected_mapping(input req_item_type item);
      rsp_item_type res;
      logic [2:0]   page;
      logic [12:0]  in_page;
      logic [3:0]   slot;
      logic [7:0]   entry;
      res     = '0;
      page    = item.cpu_address[15:13];
      // window slots other than the two I/O slots keep their place in the top page
      in_page = item.cpu_address[12:0];
      slot    = item.cpu_address[6:3];
      if (item.mode == MODE_XLATE) begin
         if (item.cpu_address[15:7] == WINDOW_TAG &&
             (slot == SLOT_CON || slot == SLOT_SDIO)) begin
            res.target      = (slot == SLOT_CON) ? TGT_CON : TGT_SDIO;
            res.phys_offset = 20'(item.cpu_address[2:0]);
            res.writable    = 1'b1;
         end else if (page == TOP_PAGE && !control_byte[CTL_ROM_OFF_BIT]) begin
            res.target      = TGT_ROM;
            res.phys_offset = 20'(in_page);
            res.writable    = 1'b0;
         end else begin
            res.target = TGT_RAM;
            if (control_byte[CTL_ENABLE_BIT]) begin
               entry           = page_entries[{control_byte[CTL_TBL_SEL_BIT], page}];
               res.phys_offset = {entry[6:0], in_page};
               res.writable    = !entry[ENT_PROTECT_BIT];
            end else begin
               res.phys_offset = {4'd0, page, in_page};
               res.writable    = 1'b1;
            end
            res.beyond_ram = (32'(res.phys_offset) >= RAM_BYTES);
         end
      end
      return res;
   endfunction

   task automatic compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         control_byte = '0;
         for (int i = 0; i < 16; i++) page_entries[i] = '0;
         mapping_q.delete();
      end else begin
         // results first: results are registered, so a result here is older
         if (rsp_strobe) begin
            if (mapping_q.size() == 0) begin
               $error("rsp_item: expected no item, actual target %0h offset %0h",
                      rsp_item.target, rsp_item.phys_offset);
               errors++;
            end else begin
               oldest = mapping_q.pop_front();
               compare_field("target", oldest.target, rsp_item.target);
               compare_field("phys_offset", oldest.phys_offset, rsp_item.phys_offset);
               compare_field("writable", oldest.writable, rsp_item.writable);
               compare_field("beyond_ram", oldest.beyond_ram, rsp_item.beyond_ram);
            end
         end
         if (start && !busy) begin
            mapping_q.push_back(expected_mapping(req_item));
            case (req_item.mode)
               MODE_CTL_WRITE: begin
                  if (!req_item.data_byte[CTL_IGNORE_BIT]) control_byte = req_item.data_byte;
               end
               MODE_ENT_WRITE: begin
                  page_entries[control_byte[3:0]] = req_item.data_byte;
               end
               default: ;
            endcase
         end
      end
      mismatch_count <= errors;
      pending_count  <= mapping_q.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// tb: top of the paged_memory_mapper testbench; makes reset, clock and items.
// Depends on pmm_pkg, paged_memory_mapper and pmm_bus_checker.
module tb;
   import pmm_pkg::*;

   // the fourth mode has no name in the package; the block must answer it with zeros
   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 650;
   // last stretch of the random part runs with start held high
   localparam int         STEADY_TAIL  = 100;
   // slowest correct run is about 700 items with their gaps; this is far beyond it
   localparam int         CYCLE_LIMIT  = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   int           mismatch_count;
   int           pending_count;
   int           cycle_count = 0;

   always #10 clock = ~clock;

   paged_memory_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   pmm_bus_checker checker_0 (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic req_item_type pack_item(input logic [1:0] mode,
                                              input logic [7:0] data,
                                              input logic [15:0] addr);
      req_item_type item;
      item.mode        = mode;
      item.data_byte   = data;
      item.cpu_address = addr;
      return item;
   endfunction

   // Present one item and hold it until an edge takes it (start high, busy low).
   // start stays high on return, so back-to-back items need no second assignment.
   task automatic send_item(input req_item_type item);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
   endtask

   // Sender gap; the payload carries noise that must be ignored while start is low.
   task automatic sender_gap(input int cycles);
      start    <= 1'b0;
      req_item <= req_item_type'($bits(req_item_type)'($urandom));
      repeat (cycles) @(posedge clock);
   endtask

   // Addresses lean toward the top page and the FF80-FFFF window.
   function automatic logic [15:0] pick_address();
      logic [15:0] addr;
      case ($urandom_range(0, 3))
         0:       addr = 16'($urandom);
         1:       addr = 16'hFF80 | 16'($urandom_range(0, 127));
         2:       addr = 16'hE000 | 16'($urandom_range(0, 16'h1FFF));
         default: addr = 16'hFFD0 + 16'($urandom_range(0, 15));
      endcase
      return addr;
   endfunction

   // At least half of the entries point inside the installed RAM (blocks 0..15).
   function automatic logic [7:0] pick_entry();
      logic [7:0] value;
      value = 8'($urandom);
      if ($urandom_range(0, 1)) value[6:4] = 3'd0;
      return value;
   endfunction

   // Mostly accepted control writes with mapping on; some carry the drop bit.
   function automatic logic [7:0] pick_control();
      logic [7:0] value;
      value = 8'($urandom);
      if ($urandom_range(0, 7) != 0) value[CTL_IGNORE_BIT] = 1'b0;
      if ($urandom_range(0, 3) != 0) value[CTL_ENABLE_BIT] = 1'b1;
      return value;
   endfunction

   initial begin
      req_item_type item;
      int           pick;
      bit           gaps_on;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: state after reset, mapping off, ROM and the I/O window
      send_item(pack_item(MODE_XLATE, 8'h00, 16'h0000));
      send_item(pack_item(MODE_XLATE, 8'hFF, 16'hDFFF));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hE000));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hFFFF));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hFFD0));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hFFDF));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hFF80));
      // control write with the drop bit set must leave ROM in place
      send_item(pack_item(MODE_CTL_WRITE, 8'h1F, 16'hFFFF));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hFFC0));
      // ROM off, upper table, mapping on, pointer 15; protected top block
      send_item(pack_item(MODE_CTL_WRITE, 8'hEF, 16'h0000));
      send_item(pack_item(MODE_ENT_WRITE, 8'hFF, 16'h0000));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hE123));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hFFF8));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'hFFD8));
      // lower table, pointer 0: last in-range block, first block past RAM
      send_item(pack_item(MODE_CTL_WRITE, 8'h20, 16'h0000));
      send_item(pack_item(MODE_ENT_WRITE, 8'h0F, 16'h0000));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'h1FFF));
      send_item(pack_item(MODE_ENT_WRITE, 8'h10, 16'h0000));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'h0000));
      send_item(pack_item(MODE_ENT_WRITE, 8'h80, 16'h0000));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'h1234));
      // unused mode: all-zero result, no state change
      send_item(pack_item(MODE_UNUSED, 8'hFF, 16'hFFFF));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'h0001));
      send_item(pack_item(MODE_CTL_WRITE, 8'h00, 16'h0000));
      send_item(pack_item(MODE_XLATE, 8'h00, 16'h8000));

      // Random: translations dominate, with table and control traffic mixed in.
      // Gaps come in bursts; some stretches have none, and the tail has none.
      gaps_on = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
         if (gaps_on && n < RANDOM_ITEMS - STEADY_TAIL && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 16));
         pick = $urandom_range(0, 99);
         if (pick < 50)
            item = pack_item(MODE_XLATE, 8'($urandom), pick_address());
         else if (pick < 70)
            item = pack_item(MODE_CTL_WRITE, pick_control(), 16'($urandom));
         else if (pick < 95)
            item = pack_item(MODE_ENT_WRITE, pick_entry(), 16'($urandom));
         else
            item = pack_item(MODE_UNUSED, 8'($urandom), 16'($urandom));
         send_item(item);
      end
      start <= 1'b0;

      // Drain: results trail the items through the input and output registers; the watchdog bounds this wait.
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### paged_memory_mapper.f
sv/pmm_pkg.sv
sv/pmm_regs.sv
sv/pmm_xlate.sv
sv/paged_memory_mapper.sv
sv/pmm_checker.sv
tb/pmm_bus_checker.sv
tb/tb.sv
